>>> src/kmp_pkg.sv
// shared constants, codes and types of the kmp substring matcher
package kmp_pkg;

	localparam int PAT_MAX  = 16;
	localparam int PAT_AW   = $clog2(PAT_MAX);
	localparam int LEN_W    = PAT_AW + 1;
	localparam int IDX_W    = PAT_AW + 1;
	localparam int TEXT_MAX = 65536;
	localparam int TXT_W    = $clog2(TEXT_MAX);
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 16;

	localparam logic [IDX_W-1:0] NO_LINK  = '1;
	localparam logic [TXT_W-1:0] TXT_LAST = TXT_W'(TEXT_MAX - 1);

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	typedef struct packed {
		logic              op;
		logic [CHAR_W-1:0] character;
		logic              last;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} res_t;

endpackage

>>> src/kmp_ram.sv
// generic single write port ram with registered read data
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/kmp_engine.sv
// sequencer and shared byte compare unit: pattern load, failure table build, text search
module kmp_engine (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  kmp_pkg::item_t req,
	output logic         idle,
	output logic         res_valid,
	output kmp_pkg::res_t  res,
	input  logic         res_ready
);
	import kmp_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_DISP = 10'b00_0000_0010,
		S_BCHK = 10'b00_0000_0100,
		S_BRDK = 10'b00_0000_1000,
		S_BCMP = 10'b00_0001_0000,
		S_BLNK = 10'b00_0010_0000,
		S_TCHK = 10'b00_0100_0000,
		S_TCMP = 10'b00_1000_0000,
		S_TLNK = 10'b01_0000_0000,
		S_TFIN = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	item_t  item_q;
	logic [LEN_W-1:0]  len_q;
	logic              ready_q;
	logic              done_q;
	logic [IDX_W-1:0]  mi_q;
	logic [TXT_W-1:0]  tp_q;
	logic [TXT_W-1:0]  pos_q;
	logic [PAT_AW-1:0] i_q;
	logic [IDX_W-1:0]  k_q;
	logic [CHAR_W-1:0] si_q;

	// memory ports
	logic              st_we, fl_we;
	logic [PAT_AW-1:0] st_waddr, st_raddr, fl_waddr, fl_raddr;
	logic [CHAR_W-1:0] st_rdata;
	logic [IDX_W-1:0]  fl_wdata, fl_rdata;

	logic [LEN_W-1:0]  len_eff;
	logic              room;
	logic              byte_eq;
	logic              more;
	logic              hit;
	logic              need_res;
	logic [TXT_W:0]    end_pos;
	logic [TXT_W:0]    start;

	kmp_ram #(.WIDTH(CHAR_W), .DEPTH(PAT_MAX)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(item_q.character),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	kmp_ram #(.WIDTH(IDX_W), .DEPTH(PAT_MAX)) u_fail (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(fl_raddr), .rdata(fl_rdata)
	);

	// the one compare unit: stored byte against the held byte
	assign byte_eq = (st_rdata == ((state_q == S_BCMP) ? si_q : item_q.character));

	assign len_eff  = ready_q ? '0 : len_q;
	assign room     = (len_eff < LEN_W'(PAT_MAX));
	assign more     = ((LEN_W'(i_q) + LEN_W'(1)) < len_q);
	assign hit      = (LEN_W'(mi_q) == len_q);
	assign need_res = hit || item_q.last;
	assign end_pos  = {1'b0, pos_q} + (TXT_W+1)'(1);
	assign start    = (len_q == '0) ? '0 :
	                  (end_pos >= (TXT_W+1)'(len_q)) ? end_pos - (TXT_W+1)'(len_q) : '0;

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_TFIN) && need_res;
	assign res.found    = hit;
	assign res.position = hit ? POS_W'(start) : '0;

	always_comb begin
		st_we    = (state_q == S_DISP) && (item_q.op == OP_PATTERN) && room;
		st_waddr = len_eff[PAT_AW-1:0];
		unique case (state_q)
			S_BCHK:  st_raddr = i_q;
			S_BRDK:  st_raddr = k_q[PAT_AW-1:0];
			default: st_raddr = mi_q[PAT_AW-1:0];
		endcase
		fl_raddr = (state_q == S_BCMP) ? k_q[PAT_AW-1:0] : mi_q[PAT_AW-1:0];
		fl_we    = 1'b0;
		fl_waddr = PAT_AW'(i_q + PAT_AW'(1));
		fl_wdata = k_q + IDX_W'(1);
		unique case (state_q)
			S_DISP: begin
				fl_we    = (item_q.op == OP_PATTERN) && item_q.last;
				fl_waddr = '0;
				fl_wdata = NO_LINK;
			end
			S_BCHK:  fl_we = more && (k_q == NO_LINK);
			S_BCMP:  fl_we = byte_eq;
			default: fl_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			ready_q <= 1'b0;
			done_q  <= 1'b0;
			mi_q    <= '0;
			tp_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (item_q.op == OP_PATTERN) begin
						ready_q <= 1'b0;
						mi_q    <= '0;
						tp_q    <= '0;
						done_q  <= 1'b0;
						len_q   <= len_eff + LEN_W'(room);
						state_q <= item_q.last ? S_BCHK : S_IDLE;
					end else if (!ready_q) begin
						state_q <= S_IDLE;
					end else if (done_q) begin
						if (item_q.last) begin
							mi_q   <= '0;
							tp_q   <= '0;
							done_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end else begin
						if (tp_q != TXT_LAST) begin
							tp_q <= tp_q + TXT_W'(1);
						end
						state_q <= (len_q == '0) ? S_TFIN : S_TCHK;
					end
				end
				S_BCHK: begin
					if (!more) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (k_q == NO_LINK) begin
						state_q <= S_BCHK;
					end else begin
						state_q <= S_BRDK;
					end
				end
				S_BRDK: state_q <= S_BCMP;
				S_BCMP: state_q <= byte_eq ? S_BCHK : S_BLNK;
				S_BLNK: state_q <= S_BCHK;
				S_TCHK: begin
					if (mi_q == NO_LINK) begin
						mi_q    <= '0;
						state_q <= S_TFIN;
					end else begin
						state_q <= S_TCMP;
					end
				end
				S_TCMP: begin
					if (byte_eq) begin
						mi_q    <= mi_q + IDX_W'(1);
						state_q <= S_TFIN;
					end else begin
						state_q <= S_TLNK;
					end
				end
				S_TLNK: begin
					mi_q    <= fl_rdata;
					state_q <= S_TCHK;
				end
				S_TFIN: begin
					if (!need_res || res_ready) begin
						if (item_q.last) begin
							mi_q   <= '0;
							tp_q   <= '0;
							done_q <= 1'b0;
						end else if (hit) begin
							done_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			item_q <= req;
		end
		if (state_q == S_DISP) begin
			pos_q <= tp_q;
			i_q   <= '0;
			k_q   <= NO_LINK;
		end
		if ((state_q == S_BCHK && more && k_q == NO_LINK) ||
		    (state_q == S_BCMP && byte_eq)) begin
			i_q <= i_q + PAT_AW'(1);
			k_q <= k_q + IDX_W'(1);
		end
		if (state_q == S_BRDK) begin
			si_q <= st_rdata;
		end
		if (state_q == S_BLNK) begin
			k_q <= fl_rdata;
		end
	end
endmodule

>>> src/kmp_substring_match.sv
// top level of the kmp substring matcher: input handshake and result register
//
//  channel | signals                               | transfer when
//  --------+---------------------------------------+----------------------
//  in      | in_valid in_ready op character last   | in_valid && in_ready
//  out     | out_valid out_ready found position    | out_valid && out_ready
//
// one item is worked on at a time; in_ready is high only while the sequencer idles
// pattern byte: stored at dispatch; the last one adds a failure table build of
// at most about 2 * pattern length comparisons, each a check, read and compare,
// plus link on a mismatch; text byte: ignored at dispatch, else check, compare,
// finish, plus link, check, compare per failure link; memories have one read port
// arst_n clears length, ready flag and text state; memories are not cleared
// a result waits in the output register; a stalled output holds the sequencer
// at its final step, a new item is still taken while the result waits
module kmp_substring_match (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [kmp_pkg::CHAR_W-1:0]  character,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [kmp_pkg::POS_W-1:0]   position
);
	import kmp_pkg::*;

	item_t req;
	res_t  res;
	res_t  res_q;
	logic  idle;
	logic  res_valid;
	logic  res_ready;
	logic  out_valid_q;

	assign req.op        = op;
	assign req.character = character;
	assign req.last      = last;

	// the output register frees up when empty or being drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	kmp_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.req_valid(in_valid), .req(req), .idle(idle),
		.res_valid(res_valid), .res(res), .res_ready(res_ready)
	);

	assign in_ready = idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = res_q.found;
	assign position  = res_q.position;
endmodule

>>> src/kmp_checker.sv
// port level assertions for the kmp substring matcher, bound to the top level
module kmp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       op,
	input logic [kmp_pkg::CHAR_W-1:0] character,
	input logic                       last,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       found,
	input logic [kmp_pkg::POS_W-1:0]  position
);
	import kmp_pkg::*;

	// an offered item holds until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(op) && $stable(character) &&
		$stable(last))
		else $error("pending input changed");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position))
		else $error("stalled result changed");

	// a failure report carries position zero
	a_fail_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
		else $error("failure report with nonzero position");

	// an accepted item leaves the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a transfer");

	// a new result appears only while an item was being worked on
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without work in progress");
endmodule

bind kmp_substring_match kmp_checker u_kmp_checker (.*);

>>> dv/tb_kmp_substring_match.sv
// testbench of the kmp substring matcher: directed rows and random pattern/text runs
module tb_kmp_substring_match;
	timeunit 1ns;
	timeprecision 1ps;

	import kmp_pkg::*;

	// run limits, reckoned several times over the slowest correct run
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 300;
	localparam int RANDOM_ITEMS  = 500;
	localparam int PAT_GEN_MAX   = 20;
	localparam int DIR_ROWS      = 23;

	// how a directed row is checked: by the matcher model, by a value typed in, or not at all
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_RESULT
	} row_check_t;

	typedef struct packed {
		logic              op;
		logic [CHAR_W-1:0] character;
		logic              last;
		row_check_t        chk;
		res_t              res;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              op;
	logic [CHAR_W-1:0] character;
	logic              last;
	logic              out_valid;
	logic              out_ready;
	logic              found;
	logic [POS_W-1:0]  position;

	// matcher model state: stored pattern, failure links and text progress
	logic [CHAR_W-1:0] pat_mem  [PAT_MAX];
	logic [IDX_W-1:0]  link_tab [PAT_MAX];
	logic [LEN_W-1:0]  pat_len   = '0;
	bit                pat_rdy   = 1'b0;
	logic [IDX_W-1:0]  match_idx = '0;
	logic [TXT_W-1:0]  txt_pos   = '0;
	bit                srch_done = 1'b0;

	// search reports still owed by the block, oldest first
	res_t search_reports [$];

	int  mismatches     = 0;
	int  reports_seen   = 0;
	int  matches_seen   = 0;
	int  sent_items     = 0;
	int  holds_done     = 0;
	int  send_calm      = 0;
	int  recv_calm      = 0;
	bit  hold_output    = 1'b0;

	// directed rows: text before any pattern, a one-byte pattern, text bytes at the extremes,
	// a miss report, overlapping prefixes, a pattern replaced after a finished text,
	// text arriving mid-load, and a match on the last text byte
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{OP_TEXT,    8'h00, 1'b0, CHK_NONE,   '0},
		'{OP_TEXT,    8'hff, 1'b1, CHK_NONE,   '0},
		'{OP_PATTERN, 8'h00, 1'b1, CHK_NONE,   '0},
		'{OP_TEXT,    8'h00, 1'b0, CHK_RESULT, '{1'b1, 16'd0}},
		'{OP_TEXT,    8'h00, 1'b0, CHK_NONE,   '0},
		'{OP_TEXT,    8'hff, 1'b1, CHK_NONE,   '0},
		'{OP_TEXT,    8'h01, 1'b1, CHK_RESULT, '{1'b0, 16'd0}},
		'{OP_PATTERN, 8'h61, 1'b0, CHK_NONE,   '0},
		'{OP_PATTERN, 8'h61, 1'b0, CHK_NONE,   '0},
		'{OP_PATTERN, 8'h62, 1'b1, CHK_NONE,   '0},
		'{OP_TEXT,    8'h61, 1'b0, CHK_MODEL,  '0},
		'{OP_TEXT,    8'h61, 1'b0, CHK_MODEL,  '0},
		'{OP_TEXT,    8'h61, 1'b0, CHK_MODEL,  '0},
		'{OP_TEXT,    8'h62, 1'b0, CHK_MODEL,  '0},
		'{OP_TEXT,    8'h62, 1'b1, CHK_MODEL,  '0},
		'{OP_PATTERN, 8'hff, 1'b0, CHK_NONE,   '0},
		'{OP_PATTERN, 8'h00, 1'b0, CHK_NONE,   '0},
		'{OP_TEXT,    8'hff, 1'b1, CHK_NONE,   '0},
		'{OP_PATTERN, 8'hff, 1'b1, CHK_NONE,   '0},
		'{OP_TEXT,    8'hff, 1'b0, CHK_MODEL,  '0},
		'{OP_TEXT,    8'h00, 1'b0, CHK_MODEL,  '0},
		'{OP_TEXT,    8'hff, 1'b1, CHK_MODEL,  '0},
		'{OP_TEXT,    8'hff, 1'b1, CHK_MODEL,  '0}
	};

	kmp_substring_match i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.character (character),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.position  (position)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// reset once, asserted at time zero and released on a rising clock edge
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void rearm_search();
		match_idx = '0;
		txt_pos   = '0;
		srch_done = 1'b0;
	endfunction

	// advance the matcher model by one item; returns 1 when the item yields a report
	function automatic bit advance_matcher(input logic i_op, input logic [CHAR_W-1:0] ch,
			input logic lst, output res_t rpt);
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
		logic [TXT_W-1:0] at;
		int               i;
		rpt = '0;
		if (i_op == OP_PATTERN) begin
			// first byte after a finished pattern starts a fresh one
			if (pat_rdy) begin
				pat_len = '0;
				pat_rdy = 1'b0;
			end
			rearm_search();
			// bytes past the store size are dropped
			if (pat_len < PAT_MAX) begin
				pat_mem[pat_len[PAT_AW-1:0]] = ch;
				pat_len++;
			end
			if (lst) begin
				i = 0;
				k = NO_LINK;
				link_tab[0] = NO_LINK;
				while (i + 1 < int'(pat_len)) begin
					if (k == NO_LINK || pat_mem[i] == pat_mem[k[PAT_AW-1:0]]) begin
						i++;
						k++;
						link_tab[i] = k;
					end else begin
						k = link_tab[k[PAT_AW-1:0]];
					end
				end
				pat_rdy = 1'b1;
			end
			return 1'b0;
		end
		// text with no finished pattern is dropped
		if (!pat_rdy)
			return 1'b0;
		// rest of a text that already matched
		if (srch_done) begin
			if (lst)
				rearm_search();
			return 1'b0;
		end
		at = txt_pos;
		if (txt_pos != TXT_LAST)
			txt_pos++;
		if (pat_len == '0) begin
			rpt.found = 1'b1;
		end else begin
			j = match_idx;
			while (j != NO_LINK && ch != pat_mem[j[PAT_AW-1:0]])
				j = link_tab[j[PAT_AW-1:0]];
			j++;
			match_idx = j;
			if (j == pat_len) begin
				rpt.found = 1'b1;
				if (int'(at) + 1 >= int'(pat_len))
					rpt.position = POS_W'(int'(at) + 1 - int'(pat_len));
			end else if (!lst) begin
				return 1'b0;
			end
		end
		if (lst)
			rearm_search();
		else
			srch_done = 1'b1;
		return 1'b1;
	endfunction

	// idle cycles before the next transfer; calm stretches run with none
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(15, 40);
		return $urandom_range(0, 14);
	endfunction

	// offer one item, wait for its transfer, then log what it should produce
	task automatic transfer_item(input logic i_op, input logic [CHAR_W-1:0] ch,
			input logic lst, input row_check_t chk, input res_t typed);
		int   gap;
		res_t rpt;
		bit   has;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= i_op;
		character <= ch;
		last      <= lst;
		do @(posedge clk); while (!in_ready);
		has = advance_matcher(i_op, ch, lst, rpt);
		if (chk == CHK_MODEL && has)
			search_reports.push_back(rpt);
		else if (chk == CHK_RESULT)
			search_reports.push_back(typed);
		sent_items++;
	endtask

	task automatic send_byte(input logic i_op, input logic [CHAR_W-1:0] ch, input logic lst);
		transfer_item(i_op, ch, lst, CHK_MODEL, '0);
	endtask

	// sender stops offering and stays quiet until every owed report has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (search_reports.size() != 0)
			@(posedge clk);
	endtask

	// result side: random back-pressure, one long hold on request, field checks
	initial begin : result_sink
		int   gap;
		res_t want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				// long hold: the block fills up and must stall its input
				hold_output = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				gap = draw_gap(recv_calm);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			reports_seen++;
			if (found === 1'b1)
				matches_seen++;
			if (search_reports.size() == 0) begin
				$error("report with nothing owed: found %0b position %0d", found, position);
				mismatches++;
			end else begin
				want = search_reports.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0b, actual %0b", want.found, found);
					mismatches++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					mismatches++;
				end
			end
		end
	end

	// watchdog on the whole run
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// stimulus: directed rows, then random pattern/text runs
	initial begin : stimulus
		logic [CHAR_W-1:0] pat [PAT_GEN_MAX];
		logic [CHAR_W-1:0] base;
		logic [CHAR_W-1:0] ch;
		int                plen;
		int                tlen;
		int                off;
		int                total;
		int                texts;
		int                seqs;
		int                rand_items;
		bit                embed;
		in_valid  <= 1'b0;
		op        <= OP_PATTERN;
		character <= '0;
		last      <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (dir_rows[r])
			transfer_item(dir_rows[r].op, dir_rows[r].character, dir_rows[r].last,
				dir_rows[r].chk, dir_rows[r].res);
		wait_drained();

		seqs = 0;
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			seqs++;
			// long output hold while this run keeps offering items
			if (seqs == 4 || seqs == 40)
				hold_output = 1'b1;
			// now and then let everything drain before the next run
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			if ($urandom_range(0, 7) == 0) begin
				// noise: any op, any byte, any end mark
				repeat ($urandom_range(1, 4))
					send_byte(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
				continue;
			end
			// small alphabet around a random base byte so that matches are common
			base = 8'($urandom);
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(14, PAT_GEN_MAX)
				: $urandom_range(1, 5);
			for (int i = 0; i < plen; i++)
				pat[i] = base + 8'($urandom_range(0, 2));
			for (int i = 0; i < plen; i++) begin
				// stray text is dropped once the load has begun; before the first byte it meets the old pattern
				if ($urandom_range(0, 11) == 0)
					send_byte(OP_TEXT, 8'($urandom), 1'($urandom_range(0, 1)));
				send_byte(OP_PATTERN, pat[i], i == plen - 1);
				rand_items++;
			end
			texts = $urandom_range(1, 4);
			for (int t = 0; t < texts; t++) begin
				tlen  = $urandom_range(1, 24);
				embed = $urandom_range(0, 1);
				off   = $urandom_range(0, tlen - 1);
				total = embed ? off + plen + $urandom_range(0, 3) : tlen;
				for (int n = 0; n < total; n++) begin
					if (embed && n >= off && n < off + plen)
						ch = pat[n - off];
					else
						ch = base + 8'($urandom_range(0, 2));
					send_byte(OP_TEXT, ch, n == total - 1);
					rand_items++;
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d directed rows, %0d random runs (%0d bytes), %0d long holds",
			DIR_ROWS, seqs, rand_items, holds_done);
		$display("run: %0d transfers in, %0d reports checked, %0d of them matches",
			sent_items, reports_seen, matches_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
